// ===== design/dcdt_pkg.sv =====
`default_nettype none
package dcdt_pkg;

  // request codes
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  // register addresses
  localparam logic [2:0] ADDR_LOAD   = 3'd0;
  localparam logic [2:0] ADDR_VALUE  = 3'd1;
  localparam logic [2:0] ADDR_CTRL   = 3'd2;
  localparam logic [2:0] ADDR_INTCLR = 3'd3;
  localparam logic [2:0] ADDR_RIS    = 3'd4;
  localparam logic [2:0] ADDR_MIS    = 3'd5;

  // control word bits
  localparam int CTL_ONESHOT = 0;
  localparam int CTL_SIZE32  = 1;
  localparam int CTL_PRE_LO  = 2;
  localparam int CTL_INTEN   = 5;
  localparam int CTL_PERIOD  = 6;
  localparam int CTL_ENABLE  = 7;

  // prescale codes
  localparam logic [1:0] PRE_DIV16  = 2'd1;
  localparam logic [1:0] PRE_DIV256 = 2'd2;

  localparam logic [7:0]  CTL_RESET   = 8'h20;
  localparam logic [7:0]  CTL_WR_MASK = 8'hEF;
  localparam logic [31:0] COUNT_RESET = 32'hFFFF_FFFF;

  // one registered operation as seen by a timer
  typedef struct packed {
    logic        fire;
    logic [1:0]  req_type;
    logic [2:0]  reg_addr;
    logic [31:0] write_data;
  } op_t;

endpackage
`default_nettype wire

// ===== design/dcdt_req_if.sv =====
`default_nettype none
interface dcdt_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic        timer_select;
  logic [2:0]  reg_addr;
  logic [31:0] write_data;

  modport source (output valid, req_type, timer_select, reg_addr, write_data, input ready);
  modport sink   (input valid, req_type, timer_select, reg_addr, write_data, output ready);
endinterface
`default_nettype wire

// ===== design/dcdt_rsp_if.sv =====
`default_nettype none
interface dcdt_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic [1:0]  irq_lines;

  modport source (output valid, read_data, irq_lines, input ready);
  modport sink   (input valid, read_data, irq_lines, output ready);
endinterface
`default_nettype wire

// ===== design/dcdt_timer.sv =====
`default_nettype none
module dcdt_timer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire dcdt_pkg::op_t op,
  output logic [31:0]      read_data,
  output logic             irq_next
);

  logic [7:0]  ctl;
  logic [31:0] reload;
  logic [31:0] count;
  logic        raw;
  logic [7:0]  pre;

  logic [7:0]  ctl_next;
  logic [31:0] reload_next;
  logic [31:0] count_next;
  logic        raw_next;
  logic [7:0]  pre_next;

  logic [31:0] mask;
  logic [31:0] cur;
  logic [31:0] step_val;
  logic [8:0]  pre_inc;
  logic        terminal;
  logic [1:0]  pre_code;

  // counter size and current count
  assign mask     = ctl[dcdt_pkg::CTL_SIZE32] ? 32'hFFFF_FFFF : 32'h0000_FFFF;
  assign cur      = count & mask;
  assign pre_code = ctl[dcdt_pkg::CTL_PRE_LO +: 2];
  assign pre_inc  = {1'b0, pre} + 9'd1;

  // prescaler terminal count
  always_comb begin
    case (pre_code)
      dcdt_pkg::PRE_DIV16:  terminal = (pre_inc >= 9'd16);
      dcdt_pkg::PRE_DIV256: terminal = (pre_inc >= 9'd256);
      default:              terminal = 1'b1;
    endcase
  end

  // value after one counter step, when not halting
  always_comb begin
    if (cur != 32'd0) begin
      step_val = cur - 32'd1;
    end else if (ctl[dcdt_pkg::CTL_PERIOD]) begin
      step_val = reload & mask;
    end else begin
      step_val = mask;
    end
  end

  // state update for the operation in hand
  always_comb begin
    ctl_next    = ctl;
    reload_next = reload;
    count_next  = count;
    raw_next    = raw;
    pre_next    = pre;
    read_data   = 32'd0;
    if (op.fire) begin
      case (op.req_type)
        dcdt_pkg::REQ_TICK: begin
          if (ctl[dcdt_pkg::CTL_ENABLE]) begin
            if (terminal) begin
              pre_next = 8'd0;
              if (cur == 32'd0 && ctl[dcdt_pkg::CTL_ONESHOT]) begin
                count_next = 32'd0;
              end else begin
                count_next = step_val;
                if (step_val == 32'd0) raw_next = 1'b1;
              end
            end else begin
              pre_next = pre_inc[7:0];
            end
          end
        end
        dcdt_pkg::REQ_WRITE: begin
          unique case (op.reg_addr)
            dcdt_pkg::ADDR_LOAD: begin
              reload_next = op.write_data;
              count_next  = op.write_data;
            end
            dcdt_pkg::ADDR_CTRL:   ctl_next = op.write_data[7:0] & dcdt_pkg::CTL_WR_MASK;
            dcdt_pkg::ADDR_INTCLR: raw_next = 1'b0;
            default: ;
          endcase
        end
        dcdt_pkg::REQ_READ: begin
          unique case (op.reg_addr)
            dcdt_pkg::ADDR_LOAD:  read_data = reload;
            dcdt_pkg::ADDR_VALUE: read_data = cur;
            dcdt_pkg::ADDR_CTRL:  read_data = {24'd0, ctl};
            dcdt_pkg::ADDR_RIS:   read_data = {31'd0, raw};
            dcdt_pkg::ADDR_MIS:   read_data = {31'd0, raw & ctl[dcdt_pkg::CTL_INTEN]};
            default:              read_data = 32'd0;
          endcase
        end
        default: ;
      endcase
    end
  end

  // masked interrupt after the operation
  assign irq_next = raw_next & ctl_next[dcdt_pkg::CTL_INTEN];

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl    <= dcdt_pkg::CTL_RESET;
      reload <= 32'd0;
      count  <= dcdt_pkg::COUNT_RESET;
      raw    <= 1'b0;
      pre    <= 8'd0;
    end else begin
      ctl    <= ctl_next;
      reload <= reload_next;
      count  <= count_next;
      raw    <= raw_next;
      pre    <= pre_next;
    end
  end

endmodule
`default_nettype wire

// ===== design/dual_down_counter_timer_unit.sv =====
// pipeline: an accepted beat passes through the input register, then the result register
// throughput: one beat per cycle while rsp.ready is high; each timer's state is updated in the cycle
//   between the input register and the result register
// reset (synchronous): control 0x20, load 0, value all ones, interrupts and
//   prescalers cleared, both pipeline registers emptied
`default_nettype none
module dual_down_counter_timer_unit #(
  parameter int NUM_TIMERS = 2
) (
  input  wire logic clk,
  input  wire logic rst,
  dcdt_req_if.sink   req,
  dcdt_rsp_if.source rsp
);

  localparam int MAX_TIMERS = 2;

  logic        in_valid;
  logic [1:0]  in_req_type;
  logic        in_sel;
  logic [2:0]  in_addr;
  logic [31:0] in_data;

  logic        out_valid;
  logic [31:0] out_read_data;
  logic [1:0]  out_irq;

  logic        advance;
  logic        fire;
  logic [31:0] rd [MAX_TIMERS];
  logic [1:0]  irq_next;

  // stage handshakes
  assign advance   = !out_valid || rsp.ready;
  assign fire      = in_valid && advance;
  assign req.ready = !in_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.ready) begin
      in_valid <= req.valid;
    end
    if (req.ready && req.valid) begin
      in_req_type <= req.req_type;
      in_sel      <= req.timer_select;
      in_addr     <= req.reg_addr;
      in_data     <= req.write_data;
    end
  end

  // timer channels
  for (genvar k = 0; k < MAX_TIMERS; k++) begin : g_timer
    if (k < NUM_TIMERS) begin : g_on
      dcdt_pkg::op_t op;
      assign op.fire       = fire && (in_sel == 1'(k));
      assign op.req_type   = in_req_type;
      assign op.reg_addr   = in_addr;
      assign op.write_data = in_data;

      dcdt_timer u_timer (
        .clk       (clk),
        .rst       (rst),
        .op        (op),
        .read_data (rd[k]),
        .irq_next  (irq_next[k])
      );
    end else begin : g_off
      assign rd[k]       = 32'd0;
      assign irq_next[k] = 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
    if (fire) begin
      out_read_data <= rd[0] | rd[1];
      out_irq       <= irq_next;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.read_data = out_read_data;
  assign rsp.irq_lines = out_irq;

endmodule
`default_nettype wire
